// ===== hw/rtl/tss_pkg.sv =====
// Shared types, codes and constants for the traffic signal sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

   // Lamp and arrow bit positions inside lamp_bits and yellow_marks.
   localparam logic [7:0] L_N = 8'd8;
   localparam logic [7:0] L_S = 8'd4;
   localparam logic [7:0] L_E = 8'd2;
   localparam logic [7:0] L_W = 8'd1;
   localparam logic [7:0] A_N = 8'd128;
   localparam logic [7:0] A_S = 8'd64;
   localparam logic [7:0] A_E = 8'd32;
   localparam logic [7:0] A_W = 8'd16;

   // Traffic phases.
   localparam logic [3:0] PH_STOP    = 4'd0;
   localparam logic [3:0] PH_NS_GO   = 4'd1;
   localparam logic [3:0] PH_EW_GO   = 4'd2;
   localparam logic [3:0] PH_NS_TURN = 4'd3;
   localparam logic [3:0] PH_EW_TURN = 4'd4;
   localparam logic [3:0] PH_N_TURN  = 4'd5;
   localparam logic [3:0] PH_S_TURN  = 4'd6;
   localparam logic [3:0] PH_E_TURN  = 4'd7;
   localparam logic [3:0] PH_W_TURN  = 4'd8;

   // Sequence steps of the main and preemption cycles.
   localparam logic [3:0] ST_STOP_Y      = 4'd0;
   localparam logic [3:0] ST_STOP_HOLD   = 4'd1;
   localparam logic [3:0] ST_CHANGE      = 4'd2;
   localparam logic [3:0] ST_HOLD        = 4'd3;
   localparam logic [3:0] ST_AXIS_CHANGE = 4'd4;
   localparam logic [3:0] ST_AXIS_HOLD   = 4'd5;
   localparam logic [3:0] ST_P_STOP_Y    = 4'd6;
   localparam logic [3:0] ST_P_STOP_HOLD = 4'd7;
   localparam logic [3:0] ST_P_CHANGE    = 4'd8;
   localparam logic [3:0] ST_P_HOLD      = 4'd9;

   // Lamp codes on the result word.
   localparam logic [1:0] LAMP_RED    = 2'd0;
   localparam logic [1:0] LAMP_YELLOW = 2'd1;
   localparam logic [1:0] LAMP_GREEN  = 2'd2;

   // Walk codes on the result word.
   localparam logic [1:0] WALK_NONE = 2'd0;
   localparam logic [1:0] WALK_NS   = 2'd1;
   localparam logic [1:0] WALK_EW   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_YELLOW        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALL_RED       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GO_AFTER_TURN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GO            = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREEMPT       = 3'd5;

   // Configuration reset values.
   localparam logic [7:0] RST_YELLOW        = 8'd2;
   localparam logic [7:0] RST_ALL_RED       = 8'd3;
   localparam logic [7:0] RST_TURN          = 8'd4;
   localparam logic [7:0] RST_GO_AFTER_TURN = 8'd7;
   localparam logic [7:0] RST_GO            = 8'd10;
   localparam logic [7:0] RST_PREEMPT       = 8'd10;

   localparam logic [7:0] TICK_MAX = 8'd255;

   typedef struct packed {
      logic [7:0] yellow_ticks;
      logic [7:0] all_red_ticks;
      logic [7:0] turn_ticks;
      logic [7:0] go_after_turn_ticks;
      logic [7:0] go_ticks;
      logic [7:0] preempt_ticks;
   } cfg_type;

   typedef struct packed {
      logic [3:0] traffic_phase;
      logic [3:0] sequence_step;
      logic [7:0] tick_count;
      logic [7:0] lamp_bits;
      logic [7:0] yellow_marks;
      logic [3:0] deferred_green;
      logic       preempt_active;
   } state_type;

   // Result fields, last member in the lowest bits.
   typedef struct packed {
      logic [1:0] walk_signal;
      logic [1:0] west_arrow;
      logic [1:0] east_arrow;
      logic [1:0] south_arrow;
      logic [1:0] north_arrow;
      logic [1:0] west_lamp;
      logic [1:0] east_lamp;
      logic [1:0] south_lamp;
      logic [1:0] north_lamp;
   } rsp_type;

   // Green pattern of each traffic phase; unknown phases show all red.
   function automatic logic [7:0] pattern_of(input logic [3:0] ph);
      logic [7:0] pat;
      unique case (ph)
         PH_STOP:    pat = 8'd0;
         PH_NS_GO:   pat = L_N | L_S;
         PH_EW_GO:   pat = L_E | L_W;
         PH_NS_TURN: pat = A_N | A_S;
         PH_EW_TURN: pat = A_E | A_W;
         PH_N_TURN:  pat = L_N | A_N;
         PH_S_TURN:  pat = L_S | A_S;
         PH_E_TURN:  pat = L_E | A_E;
         PH_W_TURN:  pat = L_W | A_W;
         default:    pat = 8'd0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tss_cfg.sv =====
// Configuration registers of the traffic signal sequencer.
// Depends on tss_pkg for the register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module tss_cfg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_wdata,
   output tss_pkg::cfg_type                     cfg
);
   import tss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index; indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_YELLOW:        cfg_in.yellow_ticks        = csr_wdata;
            CSR_ALL_RED:       cfg_in.all_red_ticks       = csr_wdata;
            CSR_TURN:          cfg_in.turn_ticks          = csr_wdata;
            CSR_GO_AFTER_TURN: cfg_in.go_after_turn_ticks = csr_wdata;
            CSR_GO:            cfg_in.go_ticks            = csr_wdata;
            CSR_PREEMPT:       cfg_in.preempt_ticks       = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yellow_ticks        <= RST_YELLOW;
         cfg_ff.all_red_ticks       <= RST_ALL_RED;
         cfg_ff.turn_ticks          <= RST_TURN;
         cfg_ff.go_after_turn_ticks <= RST_GO_AFTER_TURN;
         cfg_ff.go_ticks            <= RST_GO;
         cfg_ff.preempt_ticks       <= RST_PREEMPT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tss_step.sv =====
// Next-state and lamp logic for one tick of the traffic signal sequencer.
// Purely combinational; depends on tss_pkg for codes, types and patterns.
`timescale 1ns / 1ps
`default_nettype none

module tss_step (
   input  wire tss_pkg::state_type cur,
   input  wire tss_pkg::cfg_type   cfg,
   input  wire logic [3:0]         turn_request,
   input  wire logic [3:0]         ambulance_detect,
   output tss_pkg::state_type      nxt,
   output tss_pkg::rsp_type        rsp
);
   import tss_pkg::*;

   // Zero acts as one for every duration but the all-red hold.
   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   // Next phase from the last phase and the waiting turn requests.
   function automatic logic [3:0] choose_phase(input logic [3:0] ph, input logic [3:0] req);
      logic [3:0] np;
      case (ph) inside
         PH_NS_GO: begin
            if (req[2] && req[3]) np = PH_EW_TURN;
            else if (req[2])      np = PH_E_TURN;
            else if (req[3])      np = PH_W_TURN;
            else                  np = PH_EW_GO;
         end
         PH_NS_TURN, PH_N_TURN, PH_S_TURN: np = PH_NS_GO;
         PH_EW_TURN, PH_E_TURN, PH_W_TURN: np = PH_EW_GO;
         default: begin
            if (req[0] && req[1]) np = PH_NS_TURN;
            else if (req[0])      np = PH_N_TURN;
            else if (req[1])      np = PH_S_TURN;
            else                  np = PH_NS_GO;
         end
      endcase
      return np;
   endfunction

   // Start a lamp change toward a target pattern. Greens that leave go yellow;
   // a straight lamp whose opposing arrow is yellow waits for the step's end.
   function automatic state_type begin_change(input state_type s, input logic [7:0] target,
                                              input logic [3:0] step);
      state_type  r;
      logic [7:0] y;
      logic [7:0] on;
      logic [3:0] block;
      logic [3:0] hold;
      r        = s;
      y        = s.yellow_marks | (s.lamp_bits & ~target);
      on       = target & ~s.lamp_bits & ~y;
      block    = {y[6], y[7], y[4], y[5]};
      hold     = on[3:0] & block;
      r.yellow_marks   = y;
      r.deferred_green = hold;
      r.lamp_bits      = (s.lamp_bits & target) | (on & ~{4'd0, hold});
      r.sequence_step  = step;
      r.tick_count     = 8'd0;
      return r;
   endfunction

   // End a lamp change: yellows go dark and waiting greens light.
   function automatic state_type finish_change(input state_type s, input logic [3:0] step);
      state_type r;
      r = s;
      r.yellow_marks   = 8'd0;
      r.lamp_bits      = s.lamp_bits | {4'd0, s.deferred_green};
      r.deferred_green = 4'd0;
      r.sequence_step  = step;
      r.tick_count     = 8'd0;
      return r;
   endfunction

   // Leave the all-red hold toward the preemption phase or a chosen phase.
   function automatic state_type end_of_all_red(input state_type s, input logic pre,
                                                input logic [3:0] req);
      state_type r;
      r = s;
      if (pre) begin
         r = begin_change(r, pattern_of(r.traffic_phase), ST_P_CHANGE);
      end else begin
         r.traffic_phase = choose_phase(r.traffic_phase, req);
         r = begin_change(r, pattern_of(r.traffic_phase), ST_CHANGE);
      end
      return r;
   endfunction

   function automatic logic [1:0] lamp_code(input state_type s, input logic [7:0] bit_mask);
      logic [1:0] code;
      if ((s.yellow_marks & bit_mask) != 8'd0)   code = LAMP_YELLOW;
      else if ((s.lamp_bits & bit_mask) != 8'd0) code = LAMP_GREEN;
      else                                       code = LAMP_RED;
      return code;
   endfunction

   logic [7:0] tick_inc;
   logic [7:0] step_len;
   logic       is_turn;
   state_type  fin;

   // Lamps shown during this tick come from the state before it advances.
   always_comb begin
      rsp.north_lamp  = lamp_code(cur, L_N);
      rsp.south_lamp  = lamp_code(cur, L_S);
      rsp.east_lamp   = lamp_code(cur, L_E);
      rsp.west_lamp   = lamp_code(cur, L_W);
      rsp.north_arrow = lamp_code(cur, A_N);
      rsp.south_arrow = lamp_code(cur, A_S);
      rsp.east_arrow  = lamp_code(cur, A_E);
      rsp.west_arrow  = lamp_code(cur, A_W);
      rsp.walk_signal = WALK_NONE;
      if (cur.sequence_step >= ST_CHANGE && cur.sequence_step <= ST_AXIS_HOLD) begin
         if (cur.traffic_phase == PH_NS_GO)      rsp.walk_signal = WALK_NS;
         else if (cur.traffic_phase == PH_EW_GO) rsp.walk_signal = WALK_EW;
      end
   end

   // Length of the current step in ticks.
   always_comb begin
      case (cur.sequence_step) inside
         ST_STOP_HOLD, ST_P_STOP_HOLD: step_len = cfg.all_red_ticks;
         ST_HOLD: begin
            if (cur.traffic_phase == PH_NS_GO || cur.traffic_phase == PH_EW_GO)
               step_len = at_least_one(cfg.go_ticks);
            else
               step_len = at_least_one(cfg.turn_ticks);
         end
         ST_AXIS_HOLD: step_len = at_least_one(cfg.go_after_turn_ticks);
         ST_P_HOLD:    step_len = at_least_one(cfg.preempt_ticks);
         default:      step_len = at_least_one(cfg.yellow_ticks);
      endcase
   end

   assign tick_inc = (cur.tick_count < TICK_MAX) ? cur.tick_count + 8'd1 : cur.tick_count;
   assign is_turn  = (cur.traffic_phase >= PH_NS_TURN) && (cur.traffic_phase <= PH_W_TURN);

   // Sequence advance: ambulance preemption first, else count and end the step.
   always_comb begin
      nxt = cur;
      fin = cur;
      if (!cur.preempt_active && ambulance_detect != 4'd0) begin
         if (ambulance_detect[0])      nxt.traffic_phase = PH_N_TURN;
         else if (ambulance_detect[1]) nxt.traffic_phase = PH_S_TURN;
         else if (ambulance_detect[2]) nxt.traffic_phase = PH_E_TURN;
         else                          nxt.traffic_phase = PH_W_TURN;
         nxt.preempt_active = 1'b1;
         nxt = begin_change(nxt, 8'd0, ST_P_STOP_Y);
      end else begin
         nxt.tick_count = tick_inc;
         if (tick_inc >= step_len) begin
            unique case (cur.sequence_step) inside
               ST_STOP_Y, ST_P_STOP_Y: begin
                  fin = finish_change(nxt, (cur.sequence_step == ST_P_STOP_Y) ?
                                           ST_P_STOP_HOLD : ST_STOP_HOLD);
                  if (cfg.all_red_ticks == 8'd0)
                     nxt = end_of_all_red(fin, cur.sequence_step == ST_P_STOP_Y,
                                          turn_request);
                  else
                     nxt = fin;
               end
               ST_STOP_HOLD:   nxt = end_of_all_red(nxt, 1'b0, turn_request);
               ST_P_STOP_HOLD: nxt = end_of_all_red(nxt, 1'b1, turn_request);
               ST_CHANGE:      nxt = finish_change(nxt, ST_HOLD);
               ST_HOLD: begin
                  if (is_turn) begin
                     nxt.traffic_phase = choose_phase(cur.traffic_phase, turn_request);
                     nxt = begin_change(nxt, pattern_of(nxt.traffic_phase), ST_AXIS_CHANGE);
                  end else begin
                     nxt = begin_change(nxt, 8'd0, ST_STOP_Y);
                  end
               end
               ST_AXIS_CHANGE: nxt = finish_change(nxt, ST_AXIS_HOLD);
               ST_P_CHANGE:    nxt = finish_change(nxt, ST_P_HOLD);
               default: begin
                  // Preemption hold end, axis hold end and any unused step code return to all red.
                  nxt.preempt_active = 1'b0;
                  nxt = begin_change(nxt, 8'd0, ST_STOP_Y);
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/traffic_signal_sequencer_top.sv =====
// Top level of the traffic signal sequencer: state register, result register
// and handshakes. Depends on tss_pkg, tss_cfg and tss_step.
//
// Usage: every one-second tick is sent as one word on the req_ channel,
// tdata[3:0] turn requests and tdata[7:4] ambulance detections (bit 0 north,
// 1 south, 2 east, 3 west). For each accepted word one result word leaves on
// the rsp_ channel with the lamp states shown during that tick.
// rsp_tvalid rises in the cycle after acceptance. Throughput is one word
// per cycle: the step logic sits between the state register and the result
// register, and req_tready stays high while the result register is empty or
// being taken in the same cycle.
// When the receiver stalls, the result register holds its word and req_tready
// drops until the word is taken; no tick is lost or repeated.
// Reset (synchronous, active high) restores the default durations, puts the
// intersection at all red at the start of the change to all red, and empties
// the result register; no word is accepted while reset is high.
// The csr_ port writes the six duration registers, one per cycle of csr_wr_en,
// and is meant to be used only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module traffic_signal_sequencer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: turn_request[3:0], ambulance_detect[7:4]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,
   // rsp_tdata: north_lamp[1:0], south_lamp[3:2], east_lamp[5:4], west_lamp[7:6],
   // north_arrow[9:8], south_arrow[11:10], east_arrow[13:12], west_arrow[15:14],
   // walk_signal[17:16], zero fill[23:18]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,
   input  wire logic                            csr_wr_en,
   input  wire logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_wdata
);
   import tss_pkg::*;

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_word;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      req_fire;

   tss_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tss_step u_step (
      .cur              (state_ff),
      .cfg              (cfg),
      .turn_request     (req_tdata[3:0]),
      .ambulance_detect (req_tdata[7:4]),
      .nxt              (state_in),
      .rsp              (rsp_word)
   );

   // Accept a word whenever the result register is free or being emptied.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Sequencer state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.traffic_phase  <= PH_STOP;
         state_ff.sequence_step  <= ST_STOP_Y;
         state_ff.tick_count     <= 8'd0;
         state_ff.lamp_bits      <= 8'd0;
         state_ff.yellow_marks   <= 8'd0;
         state_ff.deferred_green <= 4'd0;
         state_ff.preempt_active <= 1'b0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded with the lamps of each accepted tick.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/tss_checker.sv =====
// Port-level checks of the traffic signal sequencer and their bind.
// Depends on traffic_signal_sequencer_top and tss_pkg for the lamp codes.
`timescale 1ns / 1ps
`default_nettype none

module tss_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [7:0]                      req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [23:0]                     rsp_tdata,
   input wire logic                            csr_wr_en,
   input wire logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [7:0]                      csr_wdata
);
   import tss_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_wr_en, csr_index, csr_wdata};

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // An empty result register never blocks the input side.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result register");

   // Every accepted tick gives a result word on the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted tick without a result word");

   // A stalled result word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   // Walk code is legal, fill bits are zero, and walk never runs with an arrow green.
   a_walk_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:16] != 2'd3 && rsp_tdata[23:18] == 6'd0 &&
                      (rsp_tdata[17:16] == WALK_NONE ||
                       (rsp_tdata[9:8] != LAMP_GREEN && rsp_tdata[11:10] != LAMP_GREEN &&
                        rsp_tdata[13:12] != LAMP_GREEN && rsp_tdata[15:14] != LAMP_GREEN))))
      else $error("illegal walk or lamp combination");

endmodule

bind traffic_signal_sequencer_top tss_checker u_tss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wr_en  (csr_wr_en),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire

// ===== tb/traffic_signal_sequencer_top_tb.sv =====
// Self-checking testbench for traffic_signal_sequencer_top: it predicts every lamp word
// from the ticks it sends and compares each returned word field by field.
// Depends on tss_pkg and the traffic_signal_sequencer_top RTL only.
`timescale 1ns / 1ps

module traffic_signal_sequencer_top_tb;
   import tss_pkg::*;

   // Register indexes that no duration register answers to.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_OFF_AFTER = 500;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // req_tdata: turn_request[3:0], ambulance_detect[7:4]
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rsp_tdata: north_lamp, south_lamp, east_lamp, west_lamp, north_arrow,
   // south_arrow, east_arrow, west_arrow, walk_signal (2 bits each), zero fill
   logic [23:0]            rsp_tdata;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   // Lamp predictor and store of expected lamp words.
   class lamp_board;
      logic [7:0] yellow_len, all_red_len, turn_len, go_after_turn_len, go_len, preempt_len;
      logic [3:0] phase, step, waiting;
      logic [7:0] ticks, lit, yel;
      bit         preempting;
      rsp_type    expected_lamps[$];
      int         ticks_noted;
      int         mismatches;

      function new();
         yellow_len = RST_YELLOW;
         all_red_len = RST_ALL_RED;
         turn_len = RST_TURN;
         go_after_turn_len = RST_GO_AFTER_TURN;
         go_len = RST_GO;
         preempt_len = RST_PREEMPT;
         phase = PH_STOP;
         step = ST_STOP_Y;
         ticks = 8'd0;
         lit = 8'd0;
         yel = 8'd0;
         waiting = 4'd0;
         preempting = 1'b0;
         ticks_noted = 0;
         mismatches = 0;
      endfunction

      function void set_duration(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
         case (index)
            CSR_YELLOW:        yellow_len = value;
            CSR_ALL_RED:       all_red_len = value;
            CSR_TURN:          turn_len = value;
            CSR_GO_AFTER_TURN: go_after_turn_len = value;
            CSR_GO:            go_len = value;
            CSR_PREEMPT:       preempt_len = value;
            default:           ;
         endcase
      endfunction

      function int pending();
         return expected_lamps.size();
      endfunction

      // A zero duration behaves as one tick, except for the all-red hold.
      function logic [7:0] min_one(logic [7:0] v);
         return (v == 8'd0) ? 8'd1 : v;
      endfunction

      function logic [7:0] green_set(logic [3:0] ph);
         case (ph)
            PH_NS_GO:   return L_N | L_S;
            PH_EW_GO:   return L_E | L_W;
            PH_NS_TURN: return A_N | A_S;
            PH_EW_TURN: return A_E | A_W;
            PH_N_TURN:  return L_N | A_N;
            PH_S_TURN:  return L_S | A_S;
            PH_E_TURN:  return L_E | A_E;
            PH_W_TURN:  return L_W | A_W;
            default:    return 8'd0;
         endcase
      endfunction

      // Next phase from the last one and the turn requests (bit 0 N .. bit 3 W).
      function logic [3:0] next_phase(logic [3:0] ph, logic [3:0] req);
         case (ph)
            PH_NS_GO: begin
               if (req[2] && req[3]) return PH_EW_TURN;
               if (req[2]) return PH_E_TURN;
               if (req[3]) return PH_W_TURN;
               return PH_EW_GO;
            end
            PH_NS_TURN, PH_N_TURN, PH_S_TURN: return PH_NS_GO;
            PH_EW_TURN, PH_E_TURN, PH_W_TURN: return PH_EW_GO;
            default: begin
               if (req[0] && req[1]) return PH_NS_TURN;
               if (req[0]) return PH_N_TURN;
               if (req[1]) return PH_S_TURN;
               return PH_NS_GO;
            end
         endcase
      endfunction

      // Start a lamp change: greens leaving the target turn yellow, and a straight
      // lamp whose opposing arrow is yellow waits for the end of the change.
      function void start_change(logic [7:0] target, logic [3:0] next_step);
         logic [7:0] y;
         logic [7:0] on;
         logic [3:0] blocked;
         logic [3:0] held_back;
         y = yel | (lit & ~target);
         on = target & ~lit & ~y;
         blocked = {|(y & A_S), |(y & A_N), |(y & A_W), |(y & A_E)};
         held_back = on[3:0] & blocked;
         yel = y;
         waiting = held_back;
         lit = (lit & target) | (on & ~{4'h0, held_back});
         step = next_step;
         ticks = 8'd0;
      endfunction

      function void finish_change(logic [3:0] next_step);
         yel = 8'd0;
         lit = lit | {4'h0, waiting};
         waiting = 4'd0;
         step = next_step;
         ticks = 8'd0;
      endfunction

      function logic [7:0] step_length();
         case (step)
            ST_STOP_HOLD, ST_P_STOP_HOLD: return all_red_len;
            ST_HOLD:
               return (phase == PH_NS_GO || phase == PH_EW_GO) ? min_one(go_len)
                                                                : min_one(turn_len);
            ST_AXIS_HOLD: return min_one(go_after_turn_len);
            ST_P_HOLD:    return min_one(preempt_len);
            default:      return min_one(yellow_len);
         endcase
      endfunction

      function void end_all_red(bit pre, logic [3:0] req);
         if (pre) begin
            start_change(green_set(phase), ST_P_CHANGE);
         end else begin
            phase = next_phase(phase, req);
            start_change(green_set(phase), ST_CHANGE);
         end
      endfunction

      function void end_step(logic [3:0] req);
         bit pre;
         case (step)
            ST_STOP_Y, ST_P_STOP_Y: begin
               pre = (step == ST_P_STOP_Y);
               finish_change(pre ? ST_P_STOP_HOLD : ST_STOP_HOLD);
               // No all-red hold: decide on this same tick.
               if (all_red_len == 8'd0) end_all_red(pre, req);
            end
            ST_STOP_HOLD:   end_all_red(1'b0, req);
            ST_P_STOP_HOLD: end_all_red(1'b1, req);
            ST_CHANGE:      finish_change(ST_HOLD);
            ST_HOLD: begin
               if (phase >= PH_NS_TURN && phase <= PH_W_TURN) begin
                  phase = next_phase(phase, req);
                  start_change(green_set(phase), ST_AXIS_CHANGE);
               end else begin
                  start_change(8'd0, ST_STOP_Y);
               end
            end
            ST_AXIS_CHANGE: finish_change(ST_AXIS_HOLD);
            ST_P_CHANGE:    finish_change(ST_P_HOLD);
            default: begin
               preempting = 1'b0;
               start_change(8'd0, ST_STOP_Y);
            end
         endcase
      endfunction

      function logic [1:0] shade(logic [7:0] mask);
         if ((yel & mask) != 8'd0) return LAMP_YELLOW;
         if ((lit & mask) != 8'd0) return LAMP_GREEN;
         return LAMP_RED;
      endfunction

      // An accepted tick: record the lamps shown during it, then advance.
      function void note_tick(logic [7:0] word);
         logic [3:0] req;
         logic [3:0] amb;
         rsp_type    want;
         req = word[3:0];
         amb = word[7:4];
         want.north_lamp = shade(L_N);
         want.south_lamp = shade(L_S);
         want.east_lamp = shade(L_E);
         want.west_lamp = shade(L_W);
         want.north_arrow = shade(A_N);
         want.south_arrow = shade(A_S);
         want.east_arrow = shade(A_E);
         want.west_arrow = shade(A_W);
         want.walk_signal = WALK_NONE;
         if (step >= ST_CHANGE && step <= ST_AXIS_HOLD) begin
            if (phase == PH_NS_GO) want.walk_signal = WALK_NS;
            else if (phase == PH_EW_GO) want.walk_signal = WALK_EW;
         end
         expected_lamps.push_back(want);
         ticks_noted++;

         // An ambulance preempts unless a preemption is already running.
         if (!preempting && amb != 4'd0) begin
            phase = amb[0] ? PH_N_TURN : amb[1] ? PH_S_TURN : amb[2] ? PH_E_TURN : PH_W_TURN;
            preempting = 1'b1;
            start_change(8'd0, ST_P_STOP_Y);
         end else begin
            if (ticks < TICK_MAX) ticks++;
            if (ticks >= step_length()) end_step(req);
         end
      endfunction

      function void compare_field(string label, logic [1:0] want, logic [1:0] seen);
         if (want !== seen) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, seen);
         end
      endfunction

      function void check_lamps(logic [23:0] word);
         rsp_type want;
         rsp_type seen;
         if (expected_lamps.size() == 0) begin
            mismatches++;
            $display("%0t: lamp word with no tick waiting, expected none, actual %h",
                     $time, word);
            return;
         end
         want = expected_lamps.pop_front();
         seen = rsp_type'(word[17:0]);
         compare_field("north_lamp", want.north_lamp, seen.north_lamp);
         compare_field("south_lamp", want.south_lamp, seen.south_lamp);
         compare_field("east_lamp", want.east_lamp, seen.east_lamp);
         compare_field("west_lamp", want.west_lamp, seen.west_lamp);
         compare_field("north_arrow", want.north_arrow, seen.north_arrow);
         compare_field("south_arrow", want.south_arrow, seen.south_arrow);
         compare_field("east_arrow", want.east_arrow, seen.east_arrow);
         compare_field("west_arrow", want.west_arrow, seen.west_arrow);
         compare_field("walk_signal", want.walk_signal, seen.walk_signal);
         if (word[23:18] !== 6'd0) begin
            mismatches++;
            $display("%0t: zero fill expected 0, actual %0d", $time, word[23:18]);
         end
      endfunction
   endclass

   lamp_board sb = new();
   int quiet_cycles = 0;

   traffic_signal_sequencer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Handshake monitor: results are checked before the tick of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_lamps(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_tick(req_tdata);
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("traffic_signal_sequencer_top test failed");
         $finish;
      end
   end

   // Receiver: a stall pattern picked at random among four modes, and one long hold-off.
   initial begin : rsp_side
      int  cyc;
      int  mode;
      bit  held;
      cyc = 0;
      mode = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.ticks_noted >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (cyc % 4 != 0);
            endcase
         end
      end
   end

   // Offer one tick word and hold it until it is taken.
   task automatic send_tick(input logic [3:0] turn_req, input logic [3:0] amb);
      req_tvalid <= 1'b1;
      req_tdata <= {amb, turn_req};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_duration(index, value);
   endtask

   task automatic program_durations(input logic [7:0] yellow, input logic [7:0] all_red,
                                    input logic [7:0] turn, input logic [7:0] go_after_turn,
                                    input logic [7:0] go, input logic [7:0] preempt);
      write_reg(CSR_YELLOW, yellow);
      write_reg(CSR_ALL_RED, all_red);
      write_reg(CSR_TURN, turn);
      write_reg(CSR_GO_AFTER_TURN, go_after_turn);
      write_reg(CSR_GO, go);
      write_reg(CSR_PREEMPT, preempt);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every lamp word has come back.
   task automatic wait_quiet();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Hand-picked ticks: field extremes, each ambulance direction, several at once,
   // detections during a running preemption and turn requests of every kind.
   task automatic run_directed();
      logic [7:0] words [24];
      words = '{8'h00, 8'h00, 8'h0F, 8'h01, 8'h02, 8'h10, 8'hF0, 8'h20,
                8'h00, 8'h0F, 8'h00, 8'h0C, 8'h40, 8'h80, 8'h00, 8'h04,
                8'h08, 8'hFF, 8'h00, 8'h00, 8'h60, 8'h03, 8'hC0, 8'h00};
      foreach (words[i]) send_tick(words[i][3:0], words[i][7:4]);
      req_tvalid <= 1'b0;
   endtask

   // Random ticks in bursts; ambulances come in episodes of one to forty ticks.
   task automatic run_ticks(input int count);
      int         sent;
      int         burst;
      int         gap;
      int         amb_left;
      logic [3:0] amb_val;
      logic [3:0] amb;
      sent = 0;
      amb_left = 0;
      amb_val = 4'd0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            if (amb_left == 0 && $urandom_range(0, 29) == 0) begin
               amb_val = 4'($urandom_range(1, 15));
               amb_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 4);
            end
            amb = (amb_left > 0) ? amb_val : 4'd0;
            if (amb_left > 0) amb_left--;
            send_tick(4'($urandom_range(0, 15)), amb);
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 && sent < count) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      csr_wr_en = 1'b0;
      csr_index = CSR_YELLOW;
      csr_wdata = 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset durations.
      run_directed();
      run_ticks(180);
      wait_quiet();

      // Shortest timing, all-red hold skipped.
      program_durations(8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1);
      run_ticks(250);
      wait_quiet();

      // Zero durations that count as one tick.
      program_durations(8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
      run_ticks(200);
      wait_quiet();

      // Small random durations; writes to the spare indexes must change nothing.
      program_durations(8'($urandom_range(1, 5)), 8'($urandom_range(0, 4)),
                        8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                        8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)));
      write_reg(CSR_SPARE_LOW, 8'h00);
      write_reg(CSR_SPARE_HIGH, 8'hFF);
      csr_wr_en <= 1'b0;
      run_ticks(200);
      wait_quiet();

      // Longest durations.
      program_durations(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      run_ticks(100);
      wait_quiet();

      // Mixed random durations.
      program_durations(8'($urandom_range(1, 8)), 8'($urandom_range(0, 8)),
                        8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                        8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
      run_ticks(150);
      wait_quiet();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("traffic_signal_sequencer_top test passed");
      else
         $display("traffic_signal_sequencer_top test failed");
      $finish;
   end

endmodule
